// ----- rtl/core/primitive_mesh_tessellator_assert.svh -----
// Assertion macros of the tessellator checker.
`ifndef PRIMITIVE_MESH_TESSELLATOR_ASSERT_SVH
`define PRIMITIVE_MESH_TESSELLATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define PMT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define PMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/pmt_pkg.sv -----
// Shared types, codes and helper functions of the mesh tessellator.
package pmt_pkg;

  localparam int MAX_DIVISIONS = 64;

  localparam logic [1:0] SHAPE_SPHERE    = 2'd0;
  localparam logic [1:0] SHAPE_CYLINDER  = 2'd1;
  localparam logic [1:0] SHAPE_CONE_LOW  = 2'd2;  // apex at y = 0
  localparam logic [1:0] SHAPE_CONE_HIGH = 2'd3;  // apex at y = height

  localparam logic OP_VERTEX   = 1'b0;
  localparam logic OP_TRIANGLE = 1'b1;

  localparam logic [1:0] KIND_VERTEX   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  localparam logic [2:0] REG_SHAPE    = 3'd0;
  localparam logic [2:0] REG_CENTER_X = 3'd1;
  localparam logic [2:0] REG_CENTER_Y = 3'd2;
  localparam logic [2:0] REG_CENTER_Z = 3'd3;
  localparam logic [2:0] REG_RADIUS   = 3'd4;
  localparam logic [2:0] REG_HEIGHT   = 3'd5;
  localparam logic [2:0] REG_RINGS    = 3'd6;
  localparam logic [2:0] REG_SEGMENTS = 3'd7;

  localparam int NUM_W   = 25;  // 2*num + den of a rounded quotient
  localparam int QUO_W   = 18;
  localparam int RECIP_W = 32;

  localparam logic [16:0] TEX_ONE  = 17'd65536;
  localparam logic [16:0] TEX_HALF = 17'd32768;

  typedef enum logic [1:0] {
    SIDE_TOP,
    SIDE_RIGHT,
    SIDE_BOTTOM,
    SIDE_LEFT
  } side_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [16:0] u;
    logic [16:0] v;
    logic [12:0] ca;
    logic [12:0] cb;
    logic [12:0] cc;
    logic        last;
  } result_t;

  typedef logic [RECIP_W-1:0] recip_tab_t [256];

  // ceil(2^31 / d): q = (n * R) >> 32 overshoots n / (2d) by less than one step
  function automatic recip_tab_t build_recip();
    recip_tab_t tab;
    longint unsigned num, rem, quo;
    tab[0] = '0;
    for (int d = 1; d < 256; d++) begin
      num = 64'd2147483648 + longint'(d) - 64'd1;
      rem = '0;
      quo = '0;
      // shift and subtract, one quotient bit per step
      for (int b = 31; b >= 0; b--) begin
        rem = (rem << 1) | ((num >> b) & 64'd1);
        quo = quo << 1;
        if (rem >= longint'(d)) begin
          rem = rem - longint'(d);
          quo = quo | 64'd1;
        end
      end
      tab[d] = RECIP_W'(quo);
    end
    return tab;
  endfunction

  // First-quadrant sine in Q16 from a Q30 Taylor series, f steps of a quarter turn
  function automatic logic [16:0] sin_entry(input int unsigned f, input int unsigned ab);
    longint unsigned x, x2, t, s;
    x  = (longint'(f) * 64'd1686629713) >> (ab - 2);
    x2 = (x * x) >> 30;
    t  = 64'd1073741824 - x2 / 72;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + 64'd8192) >> 14;
    if (s > 64'd65536) s = 64'd65536;
    return 17'(s);
  endfunction

  // Q16.16 times table value, rounded half away from zero
  function automatic logic signed [32:0] mulq(input logic signed [32:0] a,
                                              input logic signed [17:0] s);
    logic        neg;
    logic [31:0] ma;
    logic [16:0] ms;
    logic [48:0] m;
    neg = a[32] ^ s[17];
    ma  = a[32] ? 32'(-a) : 32'(a);
    ms  = s[17] ? 17'(-s) : 17'(s);
    m   = 49'(ma) * 49'(ms) + 49'd32768;
    return neg ? -$signed(m[48:16]) : $signed(m[48:16]);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -34'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/primitive_mesh_tessellator.sv -----
// Procedural sphere, cylinder and cone vertex and triangle generator.

// An item is taken whenever start is high and busy is low, one per cycle. Its first result
// is on the result ports, strobed by result_valid_o, after it has passed the 8 pipeline
// registers and the output register; the pipeline stalls while busy is high. Items with
// two results (triangle pairs, cylinder vertex pairs, the cone apex request) put out their
// second result in the next cycle and hold busy high for a single cycle, while the first is
// shown, since the single output port carries one result per cycle and results cannot be
// held off. Quotients use a reciprocal table and a correction step; sine and cosine come
// from two copies of a registered quarter-wave ROM with 2^(ANGLE_BITS-2)+1 entries.
// Configuration writes are always ready and must only happen while the pipeline is empty.
module primitive_mesh_tessellator #(
  parameter int ANGLE_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               opcode_i,
  input  logic [6:0]         ring_index_i,
  input  logic [6:0]         segment_index_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic [1:0]         result_kind_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic [12:0]        corner_a_o,
  output logic [12:0]        corner_b_o,
  output logic [12:0]        corner_c_o,
  output logic               last_of_run_o
);
  import pmt_pkg::*;

  localparam int AB      = ANGLE_BITS;
  localparam int TURN    = 2 ** AB;
  localparam int QUARTER = TURN / 4;
  localparam int ROM_D   = QUARTER + 1;
  localparam int ADDR_W  = AB - 1;
  localparam int NST     = 8;

  localparam logic [AB-1:0] ANG_OFF = AB'(TURN - TURN / 8);
  localparam logic [AB-1:0] ANG_QTR = AB'(QUARTER);

  typedef logic [16:0] sin_rom_t [ROM_D];

  function automatic sin_rom_t build_sin_rom();
    sin_rom_t tab;
    for (int k = 0; k < ROM_D; k++) tab[k] = sin_entry(k, AB);
    return tab;
  endfunction

  localparam sin_rom_t   SIN_ROM = build_sin_rom();
  localparam recip_tab_t RECIP   = build_recip();

  function automatic logic [ADDR_W-1:0] rom_addr(input logic [AB-1:0] a);
    logic [AB-3:0] f;
    f = a[AB-3:0];
    return a[AB-2] ? ADDR_W'(QUARTER) - ADDR_W'(f) : ADDR_W'(f);
  endfunction

  function automatic logic is_cone_f(input logic [1:0] s);
    return s == SHAPE_CONE_LOW || s == SHAPE_CONE_HIGH;
  endfunction

  typedef struct packed {
    logic                          op;
    logic                          bad;
    logic [7:0]                    rc;
    logic [7:0]                    idx_i;
    logic [6:0]                    idx_j;
    logic [12:0]                   c0;
    logic [12:0]                   c1;
    logic [12:0]                   c2;
    logic [12:0]                   c3;
    side_e                         side;
    logic [3:0][NUM_W-1:0]         num;
    logic [3:0][8:0]               den2;
    logic [3:0][RECIP_W-1:0]       rcp;
    logic [3:0][QUO_W-1:0]         quo;
    logic                          neg_sa;
    logic                          neg_ca;
    logic                          neg_sb;
    logic                          neg_cb;
    logic signed [17:0]            sin_b;
    logic signed [17:0]            cos_b;
    logic signed [32:0]            pa;
    logic signed [32:0]            pb;
    logic signed [32:0]            px;
    logic signed [32:0]            py;
    logic signed [32:0]            pz;
    logic [31:0]                   sx;
    logic [31:0]                   sy;
    logic [31:0]                   sy2;
    logic [31:0]                   sz;
    logic [16:0]                   tu;
    logic [16:0]                   tv;
  } pipe_t;

  // configuration
  logic [1:0]         shape_q;
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [30:0]        rad_q, hgt_q;
  logic [6:0]         rings_q, segs_q;

  pipe_t              st_q [NST];
  pipe_t              st_d [NST];
  logic [NST-1:0]     vld_q, vld_d;
  logic               advance, accept;

  logic [ADDR_W-1:0]  addr_sa, addr_ca, addr_sb, addr_cb;
  logic [16:0]        rom_sa_q, rom_ca_q, rom_sb_q, rom_cb_q;

  result_t            res1, res2, out_q, pend_res_q;
  logic               two, out_vld_q, pend_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = pend_q;
  assign advance     = !pend_q;
  assign accept      = start && !busy;
  assign vld_d       = {vld_q[NST-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= SHAPE_SPHERE;
      cx_q    <= '0;
      cy_q    <= '0;
      cz_q    <= '0;
      rad_q   <= 31'd6554;
      hgt_q   <= 31'd6554;
      rings_q <= 7'd16;
      segs_q  <= 7'd16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SHAPE:    shape_q <= cfg_data_i[1:0];
        REG_CENTER_X: cx_q    <= cfg_data_i;
        REG_CENTER_Y: cy_q    <= cfg_data_i;
        REG_CENTER_Z: cz_q    <= cfg_data_i;
        REG_RADIUS:   rad_q   <= cfg_data_i[30:0];
        REG_HEIGHT:   hgt_q   <= cfg_data_i[30:0];
        REG_RINGS:    rings_q <= cfg_data_i[6:0];
        REG_SEGMENTS: segs_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic                   is_cone;
    logic [7:0]             rc, pc, lim_i, ii, e, r;
    logic [8:0]             r2;
    logic [9:0]             r3;
    logic [6:0]             lim_j, jj;
    logic [14:0]            row, nrow;
    logic [3:0][NUM_W-1:0]  nm;
    logic [3:0][7:0]        dn;
    logic [56:0]            prod;
    logic [26:0]            chk;
    logic [AB-1:0]          ang_a, ang_b, cos_a, cos_b;
    logic [16:0]            d;
    logic signed [17:0]     sa, ca;
    logic signed [32:0]     rad_s, hgt_s, y2;
    pipe_t                  p;

    is_cone = shape_q inside {SHAPE_CONE_LOW, SHAPE_CONE_HIGH};
    rad_s   = $signed({2'b00, rad_q});
    hgt_s   = $signed({2'b00, hgt_q});

    // stage 0: counts, error check, index clamping
    rc = is_cone ? 8'((9'(rings_q) + 9'd3) >> 2) : 8'(rings_q);
    pc = {rc[5:0], 2'b00};
    case (shape_q)
      SHAPE_SPHERE, SHAPE_CYLINDER: lim_i = (opcode_i == OP_TRIANGLE) ? rc - 8'd1 : rc;
      default:                      lim_i = (opcode_i == OP_TRIANGLE) ? pc - 8'd1 : pc;
    endcase
    lim_j = (opcode_i == OP_TRIANGLE) ? segs_q - 7'd1 : segs_q;
    ii    = (8'(ring_index_i) > lim_i) ? lim_i : 8'(ring_index_i);
    jj    = (segment_index_i > lim_j) ? lim_j : segment_index_i;
    p       = '0;
    p.op    = opcode_i;
    p.rc    = rc;
    p.idx_i = ii;
    p.idx_j = jj;
    p.bad   = rc == 8'd0 || rc > 8'(MAX_DIVISIONS) ||
              (shape_q == SHAPE_SPHERE &&
               (segs_q == 7'd0 || 8'(segs_q) > 8'(MAX_DIVISIONS)));
    st_d[0] = p;

    // stage 1: triangle corners, cone side, divider operands
    p    = st_q[0];
    r    = p.rc;
    r2   = {r, 1'b0};
    r3   = 10'(r2) + 10'(r);
    row  = 15'(p.idx_i) * (15'(segs_q) + 15'd1);
    nrow = row + 15'(segs_q) + 15'd1;
    case (shape_q)
      SHAPE_SPHERE: begin
        p.c0 = 13'(row + 15'(p.idx_j));
        p.c1 = 13'(row + 15'(p.idx_j) + 15'd1);
        p.c2 = 13'(nrow + 15'(p.idx_j));
        p.c3 = 13'(nrow + 15'(p.idx_j) + 15'd1);
      end
      SHAPE_CYLINDER: begin
        p.c0 = 13'({p.idx_i, 1'b0});
        p.c1 = 13'({p.idx_i, 1'b0}) + 13'd1;
        p.c2 = 13'({p.idx_i, 1'b0}) + 13'd2;
        p.c3 = 13'({p.idx_i, 1'b0}) + 13'd3;
      end
      default: begin
        p.c0 = 13'(p.idx_i) + 13'd1;
        p.c1 = '0;
        p.c2 = 13'(p.idx_i) + 13'd2;
        p.c3 = '0;
      end
    endcase
    if (p.idx_i <= r) begin
      p.side = SIDE_TOP;
      e      = p.idx_i;
    end else if (9'(p.idx_i) <= r2) begin
      p.side = SIDE_RIGHT;
      e      = p.idx_i - r;
    end else if (10'(p.idx_i) <= r3) begin
      p.side = SIDE_BOTTOM;
      e      = 8'(9'(p.idx_i) - r2);
    end else begin
      p.side = SIDE_LEFT;
      e      = 8'(10'(p.idx_i) - r3);
    end
    nm = '0;
    dn = {8'd1, 8'd1, 8'd1, 8'd1};
    case (shape_q)
      SHAPE_SPHERE: begin
        nm[0] = NUM_W'(p.idx_i) << AB;
        dn[0] = {r[6:0], 1'b0};
        nm[1] = NUM_W'(p.idx_j) << AB;
        dn[1] = 8'(segs_q);
        nm[2] = NUM_W'(p.idx_i) << 16;
        dn[2] = r;
        nm[3] = NUM_W'(p.idx_j) << 16;
        dn[3] = 8'(segs_q);
      end
      SHAPE_CYLINDER: begin
        nm[0] = NUM_W'(p.idx_i) << AB;
        dn[0] = r;
        nm[2] = NUM_W'(p.idx_i) << 16;
        dn[2] = r;
      end
      default: begin
        nm[0] = NUM_W'(p.idx_i) << AB;
        dn[0] = {r[5:0], 2'b00};
        nm[2] = NUM_W'(e) << 16;
        dn[2] = r;
      end
    endcase
    for (int l = 0; l < 4; l++) begin
      p.num[l]  = {nm[l][NUM_W-2:0], 1'b0} + NUM_W'(dn[l]);
      p.den2[l] = {dn[l], 1'b0};
      p.rcp[l]  = RECIP[dn[l]];
    end
    st_d[1] = p;

    // stage 2: reciprocal multiply
    p = st_q[1];
    for (int l = 0; l < 4; l++) begin
      prod     = 57'(p.num[l]) * 57'(p.rcp[l]);
      p.quo[l] = prod[32 +: QUO_W];
    end
    st_d[2] = p;

    // stage 3: estimate is exact or one too high
    p = st_q[2];
    for (int l = 0; l < 4; l++) begin
      chk = 27'(p.quo[l]) * 27'(p.den2[l]);
      if (chk > 27'(p.num[l])) p.quo[l] = p.quo[l] - QUO_W'(1);
    end
    st_d[3] = p;

    // stage 4: angles and ROM addresses
    p        = st_q[3];
    ang_a    = is_cone ? ANG_OFF + p.quo[0][AB-1:0] : p.quo[0][AB-1:0];
    ang_b    = p.quo[1][AB-1:0];
    cos_a    = ang_a + ANG_QTR;
    cos_b    = ang_b + ANG_QTR;
    addr_sa  = rom_addr(ang_a);
    addr_ca  = rom_addr(cos_a);
    addr_sb  = rom_addr(ang_b);
    addr_cb  = rom_addr(cos_b);
    p.neg_sa = ang_a[AB-1];
    p.neg_ca = cos_a[AB-1];
    p.neg_sb = ang_b[AB-1];
    p.neg_cb = cos_b[AB-1];
    st_d[4]  = p;

    // stage 5: first products
    p       = st_q[4];
    sa      = p.neg_sa ? -$signed({1'b0, rom_sa_q}) : $signed({1'b0, rom_sa_q});
    ca      = p.neg_ca ? -$signed({1'b0, rom_ca_q}) : $signed({1'b0, rom_ca_q});
    p.sin_b = p.neg_sb ? -$signed({1'b0, rom_sb_q}) : $signed({1'b0, rom_sb_q});
    p.cos_b = p.neg_cb ? -$signed({1'b0, rom_cb_q}) : $signed({1'b0, rom_cb_q});
    p.pa    = mulq(rad_s, sa);
    p.pb    = mulq(rad_s, ca);
    st_d[5] = p;

    // stage 6: sphere ring radius times segment angle; other shapes take the first products and the rim height
    p = st_q[5];
    case (shape_q)
      SHAPE_SPHERE: begin
        p.px = mulq(p.pa, p.cos_b);
        p.py = p.pb;
        p.pz = mulq(p.pa, p.sin_b);
      end
      default: begin
        p.px = p.pb;
        p.py = (shape_q == SHAPE_CONE_LOW) ? hgt_s : '0;
        p.pz = p.pa;
      end
    endcase
    st_d[6] = p;

    // stage 7: center offset and texture coordinates
    p     = st_q[6];
    y2    = (shape_q == SHAPE_CONE_LOW) ? '0 : hgt_s;
    p.sx  = sat32(34'(p.px) + 34'(cx_q));
    p.sy  = sat32(34'(p.py) + 34'(cy_q));
    p.sy2 = sat32(34'(y2) + 34'(cy_q));
    p.sz  = sat32(34'(p.pz) + 34'(cz_q));
    d     = p.quo[2][16:0];
    case (shape_q)
      SHAPE_SPHERE: begin
        p.tu = d;
        p.tv = p.quo[3][16:0];
      end
      SHAPE_CYLINDER: begin
        p.tu = d;
        p.tv = TEX_ONE;
      end
      default: begin
        case (p.side)
          SIDE_TOP:    begin p.tu = d;           p.tv = '0;          end
          SIDE_RIGHT:  begin p.tu = TEX_ONE;     p.tv = d;           end
          SIDE_BOTTOM: begin p.tu = TEX_ONE - d; p.tv = TEX_ONE;     end
          default:     begin p.tu = '0;          p.tv = TEX_ONE - d; end
        endcase
      end
    endcase
    st_d[7] = p;
  end

  // two ROM copies, two read ports each
  always_ff @(posedge clk_i) begin
    if (advance) begin
      rom_sa_q <= SIN_ROM[addr_sa];
      rom_ca_q <= SIN_ROM[addr_ca];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rom_sb_q <= SIN_ROM[addr_sb];
      rom_cb_q <= SIN_ROM[addr_cb];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      st_q <= st_d;
    end
  end

  // result assembly
  always_comb begin
    pipe_t p;
    p    = st_q[NST-1];
    res1 = '0;
    res2 = '0;
    two  = 1'b0;
    if (p.bad) begin
      res1.kind = KIND_ERROR;
      res1.last = 1'b1;
    end else if (p.op == OP_TRIANGLE) begin
      res1.kind = KIND_TRIANGLE;
      res1.ca   = p.c0;
      res1.cb   = p.c1;
      res1.cc   = p.c2;
      if (is_cone_f(shape_q)) begin
        res1.last = 1'b1;
      end else begin
        two       = 1'b1;
        res2.kind = KIND_TRIANGLE;
        res2.ca   = p.c2;
        res2.cb   = p.c1;
        res2.cc   = p.c3;
        res2.last = 1'b1;
      end
    end else begin
      res1.kind = KIND_VERTEX;
      res1.px   = p.sx;
      res1.py   = p.sy;
      res1.pz   = p.sz;
      res1.u    = p.tu;
      res1.v    = p.tv;
      res1.last = 1'b1;
      case (shape_q)
        SHAPE_SPHERE: ;
        SHAPE_CYLINDER: begin
          two       = 1'b1;
          res1.last = 1'b0;
          res2      = res1;
          res2.py   = p.sy2;
          res2.v    = '0;
          res2.last = 1'b1;
        end
        default: begin
          if (p.idx_i == 8'd0) begin
            // apex first, then rim vertex at position zero
            two       = 1'b1;
            res2      = res1;
            res1.px   = cx_q;
            res1.py   = p.sy2;
            res1.pz   = cz_q;
            res1.u    = TEX_HALF;
            res1.v    = TEX_HALF;
            res1.last = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
    end else if (pend_q) begin
      out_vld_q <= 1'b1;
      pend_q    <= 1'b0;
    end else begin
      out_vld_q <= vld_q[NST-1];
      pend_q    <= vld_q[NST-1] && two;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      out_q <= pend_res_q;
    end else begin
      out_q      <= res1;
      pend_res_q <= res2;
    end
  end

  assign result_valid_o = out_vld_q;
  assign result_kind_o  = out_q.kind;
  assign pos_x_o        = out_q.px;
  assign pos_y_o        = out_q.py;
  assign pos_z_o        = out_q.pz;
  assign tex_u_o        = out_q.u;
  assign tex_v_o        = out_q.v;
  assign corner_a_o     = out_q.ca;
  assign corner_b_o     = out_q.cb;
  assign corner_c_o     = out_q.cc;
  assign last_of_run_o  = out_q.last;

endmodule

// ----- rtl/core/pmt_checker.sv -----
// Port-level checker for the mesh tessellator, bound to the top level.
`include "primitive_mesh_tessellator_assert.svh"

module pmt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       busy,
  input logic       result_valid_o,
  input logic [1:0] result_kind_o,
  input logic       last_of_run_o
);
  import pmt_pkg::*;

  // busy is only high while the first result of a pair is shown
  `PMT_ASSERT_SAME(a_busy_with_result, busy, result_valid_o, "busy without a result")
  `PMT_ASSERT_NEXT(a_busy_one_cycle, busy, !busy, "busy longer than one cycle")
  `PMT_ASSERT_NEXT(a_pair_closes, busy, result_valid_o && last_of_run_o,
                   "second result of a pair missing or not last")
  `PMT_ASSERT_NEXT(a_run_continues, result_valid_o && !last_of_run_o, result_valid_o,
                   "run broken after a non-final result")
  `PMT_ASSERT_SAME(a_error_single, result_valid_o && result_kind_o == KIND_ERROR,
                   last_of_run_o, "error result not final")

endmodule

bind primitive_mesh_tessellator pmt_checker u_pmt_checker (.*);

// ----- dv/tb_primitive_mesh_tessellator.sv -----
// Self-checking testbench of the sphere, cylinder and cone mesh tessellator.
`timescale 1ns / 1ps

module tb_primitive_mesh_tessellator;
  import pmt_pkg::*;

  localparam int ANGLE_BITS = 12;
  localparam int unsigned TURN = 1 << ANGLE_BITS;
  localparam int unsigned QUARTER = TURN >> 2;
  localparam int PIPE_DRAIN = 14;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 183;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] px, py, pz;
    logic [16:0] u, v;
    logic [12:0] ca, cb, cc;
    logic        last;
  } mesh_res_t;

  typedef struct packed {
    logic [1:0] shape;
    logic [6:0] rings;
    logic [6:0] segs;
    logic       op;
    logic [6:0] ri;
    logic [6:0] si;
    logic       err;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic opcode_i = 1'b0;
  logic [6:0] ring_index_i = '0;
  logic [6:0] segment_index_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [1:0] result_kind_o;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;
  logic [16:0] tex_u_o, tex_v_o;
  logic [12:0] corner_a_o, corner_b_o, corner_c_o;
  logic last_of_run_o;

  primitive_mesh_tessellator #(.ANGLE_BITS(ANGLE_BITS)) u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow copy of the register file
  logic [1:0] m_shape;
  longint m_cx, m_cy, m_cz, m_radius, m_height;
  int unsigned m_rings, m_segs;

  mesh_res_t mesh_expect_q[$];
  int fails = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  function automatic int unsigned div_rnd(int unsigned num, int unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic int sine_q16(int unsigned ang);
    int unsigned a, q, f;
    longint unsigned x, x2, t, s;
    a = ang & (TURN - 1);
    q = a >> (ANGLE_BITS - 2);
    f = a & (QUARTER - 1);
    if ((q & 1) != 0) f = QUARTER - f;
    x = (longint'(f) * 64'd1686629713) >> (ANGLE_BITS - 2);
    x2 = (x * x) >> 30;
    t = 64'd1073741824 - x2 / 72;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 42;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    s = (s + 8192) >> 14;
    if (s > 65536) s = 65536;
    return ((q & 2) != 0) ? -int'(s) : int'(s);
  endfunction

  function automatic int cosine_q16(int unsigned ang);
    return sine_q16(ang + QUARTER);
  endfunction

  // fixed-point product, halves rounded away from zero
  function automatic longint fx_mul(longint a, int s);
    logic neg;
    longint unsigned ma, ms, m;
    neg = (a < 0) != (s < 0);
    ma = (a < 0) ? -a : a;
    ms = (s < 0) ? -longint'(s) : longint'(s);
    m = (ma * ms + 32768) >> 16;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  task automatic push_vertex(longint x, longint y, longint z, int unsigned u,
                             int unsigned v, logic last);
    mesh_res_t r;
    r = '{kind: KIND_VERTEX, px: clamp32(x + m_cx), py: clamp32(y + m_cy),
          pz: clamp32(z + m_cz), u: u[16:0], v: v[16:0], ca: '0, cb: '0, cc: '0,
          last: last};
    mesh_expect_q.push_back(r);
  endtask

  task automatic push_tri(int unsigned a, int unsigned b, int unsigned c, logic last);
    mesh_res_t r;
    r = '{kind: KIND_TRIANGLE, px: '0, py: '0, pz: '0, u: '0, v: '0,
          ca: a[12:0], cb: b[12:0], cc: c[12:0], last: last};
    mesh_expect_q.push_back(r);
  endtask

  task automatic push_error();
    mesh_res_t r;
    r = '{kind: KIND_ERROR, px: '0, py: '0, pz: '0, u: '0, v: '0,
          ca: '0, cb: '0, cc: '0, last: 1'b1};
    mesh_expect_q.push_back(r);
  endtask

  task automatic push_cone_rim(int unsigned p, int unsigned r, logic last);
    int unsigned ang, u, v;
    longint x, z, y;
    ang = (TURN - (TURN >> 3) + div_rnd(p * TURN, 4 * r)) & (TURN - 1);
    x = fx_mul(m_radius, cosine_q16(ang));
    z = fx_mul(m_radius, sine_q16(ang));
    y = (m_shape == SHAPE_CONE_LOW) ? m_height : 0;
    if (p <= r) begin
      u = div_rnd(p * 65536, r);
      v = 0;
    end else if (p <= 2 * r) begin
      u = 65536;
      v = div_rnd((p - r) * 65536, r);
    end else if (p <= 3 * r) begin
      u = 65536 - div_rnd((p - 2 * r) * 65536, r);
      v = 65536;
    end else begin
      u = 0;
      v = 65536 - div_rnd((p - 3 * r) * 65536, r);
    end
    push_vertex(x, y, z, u, v, last);
  endtask

  task automatic predict_mesh_item(logic op, int unsigned i, int unsigned j);
    int unsigned rc, sc, ai, aj, row, nrow, u, pc;
    longint r, x, y, z;
    logic bad;
    rc = m_rings;
    sc = m_segs;
    if (m_shape == SHAPE_CONE_LOW || m_shape == SHAPE_CONE_HIGH) rc = (m_rings + 3) / 4;
    bad = rc < 1 || rc > MAX_DIVISIONS;
    if (m_shape == SHAPE_SPHERE) bad = bad || sc < 1 || sc > MAX_DIVISIONS;
    if (bad) begin
      push_error();
    end else if (m_shape == SHAPE_SPHERE) begin
      if (op == OP_VERTEX) begin
        if (i > rc) i = rc;
        if (j > sc) j = sc;
        ai = div_rnd(i * TURN, 2 * rc);
        aj = div_rnd(j * TURN, sc);
        r = fx_mul(m_radius, sine_q16(ai));
        y = fx_mul(m_radius, cosine_q16(ai));
        push_vertex(fx_mul(r, cosine_q16(aj)), y, fx_mul(r, sine_q16(aj)),
                    div_rnd(i * 65536, rc), div_rnd(j * 65536, sc), 1'b1);
      end else begin
        if (i >= rc) i = rc - 1;
        if (j >= sc) j = sc - 1;
        row = i * (sc + 1);
        nrow = row + sc + 1;
        push_tri(row + j, row + j + 1, nrow + j, 1'b0);
        push_tri(nrow + j, row + j + 1, nrow + j + 1, 1'b1);
      end
    end else if (m_shape == SHAPE_CYLINDER) begin
      if (op == OP_VERTEX) begin
        if (i > rc) i = rc;
        ai = div_rnd(i * TURN, rc);
        u = div_rnd(i * 65536, rc);
        x = fx_mul(m_radius, cosine_q16(ai));
        z = fx_mul(m_radius, sine_q16(ai));
        push_vertex(x, 0, z, u, 65536, 1'b0);
        push_vertex(x, m_height, z, u, 0, 1'b1);
      end else begin
        if (i >= rc) i = rc - 1;
        push_tri(2 * i, 2 * i + 1, 2 * i + 2, 1'b0);
        push_tri(2 * i + 2, 2 * i + 1, 2 * i + 3, 1'b1);
      end
    end else begin
      pc = 4 * rc;
      if (op == OP_VERTEX) begin
        if (i > pc) i = pc;
        if (i == 0) begin
          push_vertex(0, (m_shape == SHAPE_CONE_LOW) ? 0 : m_height, 0, 32768, 32768, 1'b0);
          push_cone_rim(0, rc, 1'b1);
        end else begin
          push_cone_rim(i, rc, 1'b1);
        end
      end else begin
        if (i >= pc) i = pc - 1;
        push_tri(i + 1, 0, i + 2, 1'b1);
      end
    end
  endtask

  task automatic send_item(logic op, logic [6:0] ri, logic [6:0] si);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start <= 1'b1;
    opcode_i <= op;
    ring_index_i <= ri;
    segment_index_i <= si;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_mesh_item(op, 32'(ri), 32'(si));
  endtask

  // pipeline must be empty before any register write
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (mesh_expect_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  // valid stays high for back-to-back writes; the caller drops it after the last one
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_SHAPE:    m_shape = data[1:0];
      REG_CENTER_X: m_cx = longint'($signed(data));
      REG_CENTER_Y: m_cy = longint'($signed(data));
      REG_CENTER_Z: m_cz = longint'($signed(data));
      REG_RADIUS:   m_radius = longint'(data[30:0]);
      REG_HEIGHT:   m_height = longint'(data[30:0]);
      REG_RINGS:    m_rings = 32'(data[6:0]);
      REG_SEGMENTS: m_segs = 32'(data[6:0]);
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_center();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 65536 * 64);
    endcase
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 11))
      0: return 32'd0;
      1: return $urandom_range(65, 127);
      2: return 32'd64;
      3: return 32'd1;
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  function automatic logic [6:0] pick_index();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(0, 66));
  endfunction

  // directed rows: shape, rings, segments, op, ring index, segment index, error
  dir_row_t dir_rows [25] = '{
    '{SHAPE_SPHERE, 7'd16, 7'd16, OP_VERTEX, 7'd0, 7'd0, 1'b0},
    '{SHAPE_SPHERE, 7'd16, 7'd16, OP_VERTEX, 7'd16, 7'd16, 1'b0},
    '{SHAPE_SPHERE, 7'd16, 7'd16, OP_VERTEX, 7'd127, 7'd127, 1'b0},
    '{SHAPE_SPHERE, 7'd16, 7'd16, OP_TRIANGLE, 7'd0, 7'd0, 1'b0},
    '{SHAPE_SPHERE, 7'd16, 7'd16, OP_TRIANGLE, 7'd127, 7'd127, 1'b0},
    '{SHAPE_SPHERE, 7'd1, 7'd1, OP_VERTEX, 7'd1, 7'd1, 1'b0},
    '{SHAPE_SPHERE, 7'd1, 7'd1, OP_TRIANGLE, 7'd0, 7'd0, 1'b0},
    '{SHAPE_SPHERE, 7'd64, 7'd64, OP_VERTEX, 7'd64, 7'd64, 1'b0},
    '{SHAPE_SPHERE, 7'd64, 7'd64, OP_TRIANGLE, 7'd63, 7'd63, 1'b0},
    '{SHAPE_SPHERE, 7'd0, 7'd16, OP_VERTEX, 7'd0, 7'd0, 1'b1},
    '{SHAPE_SPHERE, 7'd16, 7'd0, OP_TRIANGLE, 7'd0, 7'd0, 1'b1},
    '{SHAPE_SPHERE, 7'd65, 7'd16, OP_VERTEX, 7'd3, 7'd3, 1'b1},
    '{SHAPE_CYLINDER, 7'd16, 7'd0, OP_VERTEX, 7'd0, 7'd5, 1'b0},
    '{SHAPE_CYLINDER, 7'd16, 7'd0, OP_VERTEX, 7'd16, 7'd0, 1'b0},
    '{SHAPE_CYLINDER, 7'd16, 7'd0, OP_TRIANGLE, 7'd127, 7'd0, 1'b0},
    '{SHAPE_CYLINDER, 7'd0, 7'd16, OP_VERTEX, 7'd0, 7'd0, 1'b1},
    '{SHAPE_CONE_LOW, 7'd16, 7'd16, OP_VERTEX, 7'd0, 7'd0, 1'b0},
    '{SHAPE_CONE_LOW, 7'd16, 7'd16, OP_VERTEX, 7'd8, 7'd0, 1'b0},
    '{SHAPE_CONE_LOW, 7'd16, 7'd16, OP_VERTEX, 7'd127, 7'd0, 1'b0},
    '{SHAPE_CONE_LOW, 7'd16, 7'd16, OP_TRIANGLE, 7'd127, 7'd0, 1'b0},
    '{SHAPE_CONE_HIGH, 7'd1, 7'd16, OP_VERTEX, 7'd0, 7'd0, 1'b0},
    '{SHAPE_CONE_HIGH, 7'd1, 7'd16, OP_TRIANGLE, 7'd3, 7'd0, 1'b0},
    '{SHAPE_CONE_HIGH, 7'd127, 7'd16, OP_VERTEX, 7'd127, 7'd0, 1'b0},
    '{SHAPE_CONE_LOW, 7'd0, 7'd16, OP_VERTEX, 7'd0, 7'd0, 1'b1},
    '{SHAPE_CONE_HIGH, 7'd64, 7'd16, OP_VERTEX, 7'd0, 7'd0, 1'b0}
  };

  initial begin
    m_shape = SHAPE_SPHERE;
    m_cx = 0;
    m_cy = 0;
    m_cz = 0;
    m_radius = 6554;
    m_height = 6554;
    m_rings = 16;
    m_segs = 16;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].shape != m_shape || dir_rows[k].rings != m_rings ||
          dir_rows[k].segs != m_segs) begin
        drain();
        write_reg(REG_SHAPE, 32'(dir_rows[k].shape));
        write_reg(REG_RINGS, 32'(dir_rows[k].rings));
        write_reg(REG_SEGMENTS, 32'(dir_rows[k].segs));
        cfg_valid_i <= 1'b0;
      end
      if (dir_rows[k].err) begin
        send_item(dir_rows[k].op, dir_rows[k].ri, dir_rows[k].si);
        // replace the prediction with the typed-in error result
        void'(mesh_expect_q.pop_back());
        push_error();
      end else begin
        send_item(dir_rows[k].op, dir_rows[k].ri, dir_rows[k].si);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      write_reg(REG_SHAPE, $urandom_range(0, 3));
      write_reg(REG_CENTER_X, pick_center());
      write_reg(REG_CENTER_Y, pick_center());
      write_reg(REG_CENTER_Z, pick_center());
      write_reg(REG_RADIUS, pick_length());
      write_reg(REG_HEIGHT, pick_length());
      write_reg(REG_RINGS, pick_count());
      write_reg(REG_SEGMENTS, pick_count());
      cfg_valid_i <= 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_item(1'($urandom_range(0, 1)), pick_index(), pick_index());
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (mesh_expect_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
    if (fails == 0) $display("tb_primitive_mesh_tessellator passed");
    else $display("tb_primitive_mesh_tessellator failed");
    $finish;
  end

  always @(posedge clk_i) begin
    mesh_res_t e;
    if (rst_ni && result_valid_o) begin
      if (mesh_expect_q.size() == 0) begin
        $error("result with nothing expected, kind %0d", result_kind_o);
        fails++;
      end else begin
        e = mesh_expect_q.pop_front();
        if (result_kind_o !== e.kind) begin
          $error("result_kind exp %0d got %0d", e.kind, result_kind_o); fails++;
        end
        if (pos_x_o !== e.px) begin
          $error("pos_x exp %0h got %0h", e.px, pos_x_o); fails++;
        end
        if (pos_y_o !== e.py) begin
          $error("pos_y exp %0h got %0h", e.py, pos_y_o); fails++;
        end
        if (pos_z_o !== e.pz) begin
          $error("pos_z exp %0h got %0h", e.pz, pos_z_o); fails++;
        end
        if (tex_u_o !== e.u) begin
          $error("tex_u exp %0d got %0d", e.u, tex_u_o); fails++;
        end
        if (tex_v_o !== e.v) begin
          $error("tex_v exp %0d got %0d", e.v, tex_v_o); fails++;
        end
        if (corner_a_o !== e.ca) begin
          $error("corner_a exp %0d got %0d", e.ca, corner_a_o); fails++;
        end
        if (corner_b_o !== e.cb) begin
          $error("corner_b exp %0d got %0d", e.cb, corner_b_o); fails++;
        end
        if (corner_c_o !== e.cc) begin
          $error("corner_c exp %0d got %0d", e.cc, corner_c_o); fails++;
        end
        if (last_of_run_o !== e.last) begin
          $error("last_of_run exp %0d got %0d", e.last, last_of_run_o); fails++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_primitive_mesh_tessellator failed");
        $finish;
      end
    end
  end

endmodule
